>>> sv/display_reply_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// Display reply frame parser assertion macros
// Concurrent assertion helpers used by the parser top module.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_REPLY_FRAME_PARSER_DEFINES_SVH
`define DISPLAY_REPLY_FRAME_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define DRFP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("display reply frame parser assertion failed");
`define DRFP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("display reply frame parser assertion failed");
`else
`define DRFP_ASSERT(label, clk, rst, prop)
`define DRFP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> sv/drfp_pkg.sv
// ----------------------------------------------------------------------------
// Display reply frame parser package
// Shared constants, codes and structures of the parser.
// ----------------------------------------------------------------------------
package drfp_pkg;

  localparam int BUF_BYTES = 128;
  localparam int ADDR_W    = $clog2(BUF_BYTES);

  localparam logic [7:0]  BUF_LEN       = 8'(BUF_BYTES);
  localparam logic [7:0]  TERM_BYTE     = 8'hFF;
  localparam logic [1:0]  TERM_LAST     = 2'd3;
  localparam logic [15:0] DEFAULT_TICKS = 16'd100;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_SAME    = 3'd1,
    ST_CHANGED = 3'd2,
    ST_FAILED  = 3'd3,
    ST_IDLE    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_CODE = 4'b0010,
    PH_DATA = 4'b0100,
    PH_TERM = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic [7:0]  expect_code;
    logic        text_mode;
    logic [7:0]  frame_length;
    logic [15:0] timeout_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       write_valid;
    logic [6:0] write_index;
    logic [7:0] write_value;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

>>> sv/drfp_store.sv
// ----------------------------------------------------------------------------
// Display reply frame parser payload store
// Payload buffer with per-entry valid bits and a registered, bypassed read.
// ----------------------------------------------------------------------------
module drfp_store
  import drfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  store_wr_t         wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]           mem [BUF_BYTES];
  logic [BUF_BYTES-1:0] entry_valid;
  logic [7:0]           rd_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_q <= wr.data;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid[wr.addr] <= 1'b1;
      end
      rd_valid_q <= (wr.en && (wr.addr == rd_addr)) || entry_valid[rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_q : 8'd0;

endmodule

>>> sv/drfp_ctrl.sv
// ----------------------------------------------------------------------------
// Display reply frame parser control
// Receive state, timeout counter and per-item result logic.
// ----------------------------------------------------------------------------
module drfp_ctrl
  import drfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [15:0]       cfg_write_data,
  input  logic              go,
  input  item_t             item,
  input  logic [7:0]        rd_data,
  output logic [ADDR_W-1:0] rd_addr,
  output store_wr_t         wr,
  output result_t           result
);

  phase_t      phase, phase_next;
  logic [7:0]  awaited_code, awaited_code_next;
  logic        text_flag, text_flag_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  write_position, write_position_next;
  logic [1:0]  terminator_count, terminator_count_next;
  logic        changed_flag, changed_flag_next;
  logic [15:0] ticks_left, ticks_left_next;
  logic [15:0] default_ticks;

  logic [7:0]  pos_inc;
  logic [1:0]  count_inc;
  logic        is_term_byte;

  assign pos_inc      = write_position + 8'd1;
  assign count_inc    = terminator_count + 2'd1;
  assign is_term_byte = (item.rx_byte == TERM_BYTE);

  always_comb begin
    phase_next            = phase;
    awaited_code_next     = awaited_code;
    text_flag_next        = text_flag;
    payload_length_next   = payload_length;
    write_position_next   = write_position;
    terminator_count_next = terminator_count;
    changed_flag_next     = changed_flag;
    ticks_left_next       = ticks_left;
    wr                    = '0;
    result                = '0;
    result.status         = (phase == PH_IDLE) ? ST_IDLE : ST_BUSY;

    if (go) begin
      unique case (opcode_t'(item.opcode))
        OP_START: begin
          awaited_code_next     = item.expect_code;
          text_flag_next        = item.text_mode;
          payload_length_next   = (item.frame_length > BUF_LEN) ? BUF_LEN
                                                                 : item.frame_length;
          write_position_next   = 8'd0;
          terminator_count_next = 2'd0;
          changed_flag_next     = 1'b0;
          ticks_left_next       = (item.timeout_ms != 16'd0) ? item.timeout_ms
                                                              : default_ticks;
          phase_next            = PH_CODE;
          result.status         = ST_BUSY;
        end
        OP_BYTE: begin
          unique case (phase)
            PH_IDLE: begin
            end
            PH_CODE: begin
              if (item.rx_byte == awaited_code) begin
                phase_next = (payload_length == 8'd0) ? PH_TERM : PH_DATA;
              end
            end
            PH_DATA: begin
              if ((write_position < BUF_LEN) && (write_position < payload_length)) begin
                wr.en              = 1'b1;
                wr.addr            = write_position[ADDR_W-1:0];
                result.write_valid = 1'b1;
                result.write_index = write_position[6:0];
                if (text_flag && is_term_byte) begin
                  wr.data               = 8'd0;
                  result.write_value    = 8'd0;
                  terminator_count_next = 2'd1;
                  phase_next            = PH_TERM;
                end else begin
                  if ((rd_data != item.rx_byte) &&
                      !(text_flag && (pos_inc == payload_length))) begin
                    changed_flag_next = 1'b1;
                  end
                  wr.data             = item.rx_byte;
                  result.write_value  = item.rx_byte;
                  write_position_next = pos_inc;
                  if (pos_inc >= payload_length) begin
                    phase_next = PH_TERM;
                  end
                end
              end else begin
                phase_next = PH_TERM;
              end
            end
            PH_TERM: begin
              if (!is_term_byte) begin
                if (!text_flag) begin
                  phase_next    = PH_IDLE;
                  result.status = ST_FAILED;
                end
              end else begin
                terminator_count_next = count_inc;
                if (count_inc >= TERM_LAST) begin
                  phase_next    = PH_IDLE;
                  result.status = changed_flag ? ST_CHANGED : ST_SAME;
                end
              end
            end
            default: begin
            end
          endcase
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            if (ticks_left <= 16'd1) begin
              ticks_left_next = 16'd0;
              phase_next      = PH_IDLE;
              result.status   = ST_FAILED;
            end else begin
              ticks_left_next = ticks_left - 16'd1;
            end
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_addr = write_position_next[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      awaited_code     <= 8'd0;
      text_flag        <= 1'b0;
      payload_length   <= 8'd0;
      write_position   <= 8'd0;
      terminator_count <= 2'd0;
      changed_flag     <= 1'b0;
      ticks_left       <= 16'd0;
      default_ticks    <= DEFAULT_TICKS;
    end else begin
      phase            <= phase_next;
      awaited_code     <= awaited_code_next;
      text_flag        <= text_flag_next;
      payload_length   <= payload_length_next;
      write_position   <= write_position_next;
      terminator_count <= terminator_count_next;
      changed_flag     <= changed_flag_next;
      ticks_left       <= ticks_left_next;
      if (cfg_write_en) begin
        default_ticks <= cfg_write_data;
      end
    end
  end

endmodule

>>> sv/display_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// Display reply frame parser
// Parses a display module's reply frame from a stream of start, byte and
// tick items, storing the payload and reporting one status per item.
// ----------------------------------------------------------------------------
// The parser takes one item per clock cycle while its results are taken. The
// item is held in an input register, its state update and result are computed
// combinationally, and the result register loads the result when the item
// advances. A result that is not taken holds the input register, and input
// ready then follows output ready in the same cycle. The 128-byte payload
// store is read ahead at the next write position through a registered read,
// so a byte compare never stalls the pipeline. Reset clears the store through
// per-entry valid bits, with no clearing pass.
module display_reply_frame_parser
  import drfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  expect_code,
  input  logic        text_mode,
  input  logic [7:0]  frame_length,
  input  logic [15:0] timeout_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        write_valid,
  output logic [6:0]  write_index,
  output logic [7:0]  write_value
);

`include "display_reply_frame_parser_defines.svh"

  item_t             item_q;
  logic              in_full;
  logic              advance;
  result_t           result;
  result_t           result_q;
  store_wr_t         wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.opcode       <= opcode;
      item_q.rx_byte      <= rx_byte;
      item_q.expect_code  <= expect_code;
      item_q.text_mode    <= text_mode;
      item_q.frame_length <= frame_length;
      item_q.timeout_ms   <= timeout_ms;
    end
    if (advance) begin
      result_q <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  drfp_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .go             (advance),
    .item           (item_q),
    .rd_data        (rd_data),
    .rd_addr        (rd_addr),
    .wr             (wr),
    .result         (result)
  );

  drfp_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign status      = result_q.status;
  assign write_valid = result_q.write_valid;
  assign write_index = result_q.write_index;
  assign write_value = result_q.write_value;

  `DRFP_ASSERT(a_write_only_busy, clk, rst, out_valid && write_valid |-> status == ST_BUSY)
  `DRFP_ASSERT(a_no_write, clk, rst, out_valid && !write_valid |-> {write_index, write_value} == '0)
  `DRFP_ASSERT(a_advance_shows, clk, rst, advance |=> out_valid)

endmodule

>>> sim/drfp_reply_checker.sv
// ----------------------------------------------------------------------------
// Display reply frame parser checker
// Watches the item and result channels of the parser. It keeps its own
// model of the parser state and payload store, works out the result of
// every accepted item, and compares each accepted result field by field
// with the oldest one still owed.
// ----------------------------------------------------------------------------
module drfp_reply_checker
  import drfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  expect_code,
  input  logic        text_mode,
  input  logic [7:0]  frame_length,
  input  logic [15:0] timeout_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic        write_valid,
  input  logic [6:0]  write_index,
  input  logic [7:0]  write_value,
  output int          mismatch_count,
  output int          replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] dflt_ticks;
  phase_t      ph;
  logic [7:0]  want_code;
  logic        txt;
  logic [7:0]  plen;
  logic [7:0]  wpos;
  logic [1:0]  nterm;
  logic        chg;
  logic [15:0] ticks_left;
  logic [7:0]  shadow [BUF_BYTES];
  result_t     expected_replies [$];

  function automatic logic [2:0] close_frame(input logic [2:0] st);
    ph = PH_IDLE;
    return st;
  endfunction

  function automatic result_t parse_item(input opcode_t op, input logic [7:0] b,
                                         input logic [7:0] code, input logic tm,
                                         input logic [7:0] len, input logic [15:0] tmo);
    result_t r;
    int      pos;
    r = '0;
    r.status = (ph == PH_IDLE) ? ST_IDLE : ST_BUSY;
    case (op)
      OP_START: begin
        want_code  = code;
        txt        = tm;
        plen       = (len > BUF_LEN) ? BUF_LEN : len;
        wpos       = '0;
        nterm      = '0;
        chg        = 1'b0;
        ticks_left = (tmo != 16'd0) ? tmo : dflt_ticks;
        ph         = PH_CODE;
        r.status   = ST_BUSY;
      end
      OP_BYTE: begin
        if (ph == PH_CODE) begin
          if (b == want_code) ph = (plen == 8'd0) ? PH_TERM : PH_DATA;
        end else if (ph == PH_DATA) begin
          pos = wpos;
          if (pos < plen) begin
            r.write_valid = 1'b1;
            r.write_index = pos[6:0];
            if (txt && b == TERM_BYTE) begin
              shadow[pos]   = 8'd0;
              r.write_value = 8'd0;
              nterm         = 2'd1;
              ph            = PH_TERM;
            end else begin
              // In text mode the last position may differ without counting as a change.
              if (shadow[pos] != b && !(txt && pos + 1 == plen)) chg = 1'b1;
              shadow[pos]   = b;
              r.write_value = b;
              wpos          = 8'(pos + 1);
              if (pos + 1 >= plen) ph = PH_TERM;
            end
          end else begin
            ph = PH_TERM;
          end
        end else if (ph == PH_TERM) begin
          if (b != TERM_BYTE) begin
            if (!txt) r.status = close_frame(ST_FAILED);
          end else begin
            nterm = nterm + 2'd1;
            if (nterm == TERM_LAST) r.status = close_frame(chg ? ST_CHANGED : ST_SAME);
          end
        end
      end
      OP_TICK: begin
        if (ph != PH_IDLE) begin
          if (ticks_left <= 16'd1) begin
            ticks_left = '0;
            r.status   = close_frame(ST_FAILED);
          end else begin
            ticks_left = ticks_left - 16'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      dflt_ticks = DEFAULT_TICKS;
      ph         = PH_IDLE;
      want_code  = '0;
      txt        = 1'b0;
      plen       = '0;
      wpos       = '0;
      nterm      = '0;
      chg        = 1'b0;
      ticks_left = '0;
      for (int i = 0; i < BUF_BYTES; i++) shadow[i] = 8'd0;
      expected_replies.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write_en) dflt_ticks = cfg_write_data;
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          $display("%0t ns result with none owed: expected nothing, actual %0h %0h %0h %0h",
                   $time, status, write_valid, write_index, write_value);
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 8'(want.status), 8'(status));
          check_field("write_valid", 8'(want.write_valid), 8'(write_valid));
          check_field("write_index", 8'(want.write_index), 8'(write_index));
          check_field("write_value", want.write_value, write_value);
        end
      end
      if (in_valid && in_ready)
        expected_replies.push_back(parse_item(opcode_t'(opcode), rx_byte, expect_code,
                                              text_mode, frame_length, timeout_ms));
    end
    replies_owed <= expected_replies.size();
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Display reply frame parser testbench
// Drives directed and random reply frames, stray bytes, ticks and restarts
// into the parser under changing idle patterns and timeout settings, and
// leaves result checking to the reply checker, watching only for stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import drfp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  logic        clk;
  logic        rst            = 1'b1;
  logic        cfg_write_en   = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode         = OP_NOP;
  logic [7:0]  rx_byte        = '0;
  logic [7:0]  expect_code    = '0;
  logic        text_mode      = 1'b0;
  logic [7:0]  frame_length   = '0;
  logic [15:0] timeout_ms     = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [2:0]  status;
  logic        write_valid;
  logic [6:0]  write_index;
  logic [7:0]  write_value;

  int send_idle_pct = 25;
  int recv_idle_pct = 54;
  int hold_request  = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;
  int mismatch_count;
  int replies_owed;

  display_reply_frame_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .rx_byte        (rx_byte),
    .expect_code    (expect_code),
    .text_mode      (text_mode),
    .frame_length   (frame_length),
    .timeout_ms     (timeout_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .write_valid    (write_valid),
    .write_index    (write_index),
    .write_value    (write_value)
  );

  drfp_reply_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .rx_byte        (rx_byte),
    .expect_code    (expect_code),
    .text_mode      (text_mode),
    .frame_length   (frame_length),
    .timeout_ms     (timeout_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .write_valid    (write_valid),
    .write_index    (write_index),
    .write_value    (write_value),
    .mismatch_count (mismatch_count),
    .replies_owed   (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_item(input opcode_t op, input logic [7:0] b, input logic [7:0] code,
                           input logic tm, input logic [7:0] len, input logic [15:0] tmo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    rx_byte      <= b;
    expect_code  <= code;
    text_mode    <= tm;
    frame_length <= len;
    timeout_ms   <= tmo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b, 8'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic send_filler(input opcode_t op);
    send_item(op, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic sprinkle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) send_filler(OP_TICK);
    else if (r < 9) send_filler(OP_NOP);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  task automatic write_default(input logic [15:0] ticks);
    drain();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= ticks;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic run_frame();
    logic [7:0]  code;
    logic [7:0]  b;
    logic [15:0] tmo;
    logic        tm;
    logic        early;
    logic        abort;
    int          len;
    int          seed;
    int          pick;
    code  = 8'($urandom);
    tm    = 1'($urandom);
    seed  = $urandom_range(0, 2);
    early = 1'b0;
    abort = ($urandom_range(0, 19) == 0);
    pick  = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, 6);
    else if (pick < 98) len = $urandom_range(7, 24);
    else if (pick < 99) len = $urandom_range(125, 128);
    else len = $urandom_range(129, 255);
    pick = $urandom_range(0, 99);
    if (pick < 50) tmo = '0;
    else if (pick < 80) tmo = 16'($urandom);
    else tmo = 16'($urandom_range(1, 8));
    send_item(OP_START, 8'($urandom), code, tm, 8'(len), tmo);
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom);
      if (b == code) b = ~code;
      sprinkle();
      send_byte(b);
    end
    send_byte(code);
    for (int i = 0; i < len && i < BUF_BYTES; i++) begin
      sprinkle();
      if (tm && $urandom_range(0, 14) == 0) begin
        send_byte(TERM_BYTE);
        early = 1'b1;
        break;
      end
      b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(seed * 53 + i * 29 + 7);
      if (tm && b == TERM_BYTE) b = 8'h20;
      send_byte(b);
    end
    if (abort) return;
    for (int i = 0; i < (early ? 2 : 3); i++) begin
      sprinkle();
      if ($urandom_range(0, tm ? 4 : 24) == 0) begin
        send_byte(8'($urandom_range(0, 254)));
        if (!tm) return;
      end
      send_byte(TERM_BYTE);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [15:0] ticks,
                           input int count, input bit with_hold);
    int  target;
    int  mid;
    bit  paused;
    write_default(ticks);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = items_sent + count;
    mid    = items_sent + count / 2;
    paused = 1'b0;
    while (items_sent < target) begin
      if (!paused && items_sent >= mid) begin
        paused = 1'b1;
        drain();
        if (with_hold) hold_request = HOLD_CYCLES;
      end
      if ($urandom_range(0, 9) == 0) send_filler(opcode_t'($urandom_range(1, 3)));
      else run_frame();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Stray items while idle, then a text frame whose only change is at its last position.
    send_byte(TERM_BYTE);
    send_filler(OP_TICK);
    send_filler(OP_NOP);
    send_item(OP_START, 8'h00, 8'h55, 1'b1, 8'd2, 16'd0);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'h07);
    repeat (3) send_byte(TERM_BYTE);
    // Zero length binary frame that gets a bad terminator.
    send_item(OP_START, 8'hFF, 8'hAA, 1'b0, 8'd0, 16'hFFFF);
    send_byte(8'hAA);
    send_byte(8'h12);
    // Oversized length, dropped by a restart into a text frame that ends early and times out.
    send_item(OP_START, 8'h00, 8'hFF, 1'b0, 8'hFF, 16'd3);
    send_item(OP_START, 8'h00, 8'h00, 1'b1, 8'd4, 16'd2);
    send_byte(8'h00);
    send_byte(8'h41);
    send_byte(TERM_BYTE);
    send_byte(8'h33);
    send_filler(OP_TICK);
    send_byte(TERM_BYTE);
    send_filler(OP_TICK);
    send_item(OP_START, 8'h00, 8'h80, 1'b0, 8'd1, 16'd1);
    send_filler(OP_TICK);

    run_phase(25, 54, 16'd1, 330, 1'b0);
    run_phase(54, 25, 16'hFFFF, 330, 1'b0);
    run_phase(0, 0, 16'($urandom_range(2, 40)), 340, 1'b1);

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
